>>> design/lsa_pkg.sv
package lsa_pkg;

    localparam int NUM_LEDS   = 8;
    localparam int LED_IDX_W  = $clog2(NUM_LEDS);
    localparam int COLOR_W    = 24;
    localparam int PERIOD_W   = 11;
    localparam int MODE_W     = 2;

    // input queue, depth a power of two
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 11'd2000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd100;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROT_L  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROT_R  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOUNCE = 2'd3;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [1:0] CFG_ANIM_MODE   = 2'd0;
    localparam logic [1:0] CFG_STEP_PERIOD = 2'd1;

    localparam logic [COLOR_W-1:0] RAINBOW [8] = '{
        24'hff0000, 24'hff8000, 24'hffff00, 24'h00ff00,
        24'h00ffff, 24'h0000ff, 24'h800080, 24'hff0080
    };

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [PERIOD_W-1:0] period;
    } t_cfg;

    // classified word as it leaves the front end
    typedef struct packed {
        logic                 is_tick;
        logic                 wr_en;
        logic [LED_IDX_W-1:0] wr_idx;
        logic [COLOR_W-1:0]   color;
    } t_cmd;

endpackage

>>> design/lsa_front.sv
module lsa_front import lsa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_write_index,
    input  logic [23:0] i_write_color,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              w_cmd;
    logic              w_push, w_pop;

    // decode the word; out-of-range writes become no-ops here
    always_comb begin
        w_cmd.is_tick = (i_opcode == OP_TICK);
        w_cmd.wr_en   = (i_opcode == OP_WRITE) && ({1'b0, i_write_index} < 9'(NUM_LEDS));
        w_cmd.wr_idx  = i_write_index[LED_IDX_W-1:0];
        w_cmd.color   = i_write_color;
    end

    assign o_in_ready  = (r_cnt != QCNT_W'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!w_push && w_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wptr] <= w_cmd;
    end

endmodule

>>> design/lsa_back.sv
module lsa_back import lsa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_led_index,
    output logic [3:0] o_dim_red,
    output logic [3:0] o_dim_green,
    output logic [3:0] o_dim_blue,
    output logic       o_frame_last
);

    typedef enum logic [1:0] {
        ST_FETCH = 2'b01,
        ST_EMIT  = 2'b10
    } t_back_state;

    t_back_state          r_state, n_state;
    logic [COLOR_W-1:0]   r_colors [NUM_LEDS];
    logic [COLOR_W-1:0]   n_colors [NUM_LEDS];
    logic [COLOR_W-1:0]   r_snap   [NUM_LEDS];
    logic [COLOR_W-1:0]   n_snap   [NUM_LEDS];
    logic [COLOR_W-1:0]   w_base   [NUM_LEDS];
    logic [LED_IDX_W-1:0] r_step, n_step;
    logic [1:0]           r_dir, n_dir;
    logic [PERIOD_W-1:0]  r_tick, n_tick;
    logic [LED_IDX_W-1:0] r_cnt, n_cnt;
    logic                 n_out_valid;
    logic                 w_load;
    logic [1:0]           w_dir_eff, w_d;
    logic [LED_IDX_W:0]   w_st1;
    logic [LED_IDX_W:0]   w_src;
    logic [COLOR_W-1:0]   w_c;
    logic [COLOR_W-1:0]   w_emit;

    assign w_emit = r_colors[r_cnt];
    // any move of the output register: empty or being drained
    assign w_load = (r_state == ST_EMIT) && (!o_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_colors    = r_colors;
        n_snap      = r_snap;
        n_step      = r_step;
        n_dir       = r_dir;
        n_tick      = r_tick;
        n_cnt       = r_cnt;
        o_cmd_pop   = 1'b0;
        w_dir_eff   = (i_cfg.mode != MODE_BOUNCE) ? DIR_IDLE : r_dir;
        for (int i = 0; i < NUM_LEDS; i++)
            w_base[i] = (w_dir_eff == DIR_IDLE) ? r_colors[i] : r_snap[i];
        w_d         = DIR_IDLE;
        w_st1       = '0;
        w_src       = '0;
        w_c         = '0;
        n_out_valid = o_out_valid && !i_out_ready;

        unique case (r_state)
            ST_FETCH: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (!i_cmd.is_tick) begin
                        if (i_cmd.wr_en) n_colors[i_cmd.wr_idx] = i_cmd.color;
                    end else begin
                        n_dir   = w_dir_eff;
                        n_state = ST_EMIT;
                        n_cnt   = '0;
                        n_tick  = r_tick + 1'b1;
                        if (n_tick >= i_cfg.period) begin
                            n_tick = '0;
                            case (i_cfg.mode)
                                MODE_ROT_L: begin
                                    for (int i = 0; i < NUM_LEDS; i++)
                                        n_colors[i] = r_colors[(i + 1) % NUM_LEDS];
                                end
                                MODE_ROT_R: begin
                                    for (int i = 0; i < NUM_LEDS; i++)
                                        n_colors[i] = r_colors[(i + NUM_LEDS - 1) % NUM_LEDS];
                                end
                                MODE_BOUNCE: begin
                                    if (w_dir_eff == DIR_IDLE) begin
                                        n_snap = r_colors;
                                        w_st1  = '0;
                                        w_d    = DIR_FWD;
                                    end else begin
                                        w_st1  = {1'b0, r_step};
                                        w_d    = w_dir_eff;
                                    end
                                    w_st1 = w_st1 + 1'b1;
                                    // reverse at the end of a sweep
                                    if (w_st1 >= (LED_IDX_W + 1)'(NUM_LEDS - 1)) begin
                                        w_d   = (w_d == DIR_FWD) ? DIR_REV : DIR_FWD;
                                        w_st1 = '0;
                                    end
                                    n_step = w_st1[LED_IDX_W-1:0];
                                    n_dir  = w_d;
                                    for (int i = 0; i < NUM_LEDS; i++) begin
                                        w_src = (LED_IDX_W + 1)'(i) + w_st1;
                                        w_c   = (w_src >= (LED_IDX_W + 1)'(NUM_LEDS)) ? '0
                                                : w_base[w_src[LED_IDX_W-1:0]];
                                        if (w_d == DIR_FWD) n_colors[i] = w_c;
                                        else n_colors[NUM_LEDS - 1 - i] = w_c;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == LED_IDX_W'(NUM_LEDS - 1)) n_state = ST_FETCH;
                end
            end
            default: n_state = ST_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_step      <= '0;
            r_dir       <= DIR_IDLE;
            r_tick      <= '0;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++) r_colors[i] <= RAINBOW[i % 8];
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_dir       <= n_dir;
            r_tick      <= n_tick;
            r_cnt       <= n_cnt;
            o_out_valid <= n_out_valid;
            r_colors    <= n_colors;
        end
    end

    // snapshot and output payload carry no reset
    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
        if (w_load) begin
            o_led_index  <= 3'(r_cnt);
            o_dim_red    <= w_emit[23:20];
            o_dim_green  <= w_emit[15:12];
            o_dim_blue   <= w_emit[7:4];
            o_frame_last <= (r_cnt == LED_IDX_W'(NUM_LEDS - 1));
        end
    end

endmodule

>>> design/led_strip_animator.sv
// LED string animator.
// Input channel (i_in_valid / o_in_ready) takes one word: a tick
// (opcode 0) or a color write (opcode 1, index and 24-bit color).
// A write updates one LED and produces nothing; an index at or past the
// LED count is dropped. A tick advances the step prescaler, applies one
// animation step when the prescaler reaches step_period, then sends one
// output word per LED, LED 0 first, with o_frame_last on the final one.
// Words pass a two-entry queue from the decode front end to the animation
// engine. On a tick the engine runs the step, then loads each LED word
// into the output register, taking no new word until the last is loaded;
// a write only updates its LED and leaves the engine free for the next word.
// If the receiver holds i_out_ready low the output word holds, the engine
// waits, and the queue fills before o_in_ready drops.
// Config port: i_cfg_we with i_cfg_index / i_cfg_data, written by the user only
// while idle (the block does not enforce this); index 0 anim_mode, index 1
// step_period (clamped to 2000). Reset (synchronous, active low) restores
// rainbow colors, mode hold, period 100; clears prescaler, bounce state, queue.
module led_strip_animator import lsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_write_index,
    input  logic [23:0] i_write_color,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_led_index,
    output logic [3:0]  o_dim_red,
    output logic [3:0]  o_dim_green,
    output logic [3:0]  o_dim_blue,
    output logic        o_frame_last
);

    t_cfg r_cfg;
    logic w_cmd_valid, w_cmd_pop;
    t_cmd w_cmd;

    // config registers; period saturates at its maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_HOLD;
            r_cfg.period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ANIM_MODE:   r_cfg.mode <= i_cfg_data[MODE_W-1:0];
                CFG_STEP_PERIOD: r_cfg.period <= (i_cfg_data > PERIOD_MAX) ? PERIOD_MAX
                                                 : i_cfg_data;
                default: ;
            endcase
        end
    end

    lsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_write_index (i_write_index),
        .i_write_color (i_write_color),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    lsa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_led_index  (o_led_index),
        .o_dim_red    (o_dim_red),
        .o_dim_green  (o_dim_green),
        .o_dim_blue   (o_dim_blue),
        .o_frame_last (o_frame_last)
    );

endmodule

>>> tb/led_strip_animator_tb.sv
`timescale 1ns / 100ps

import lsa_pkg::*;

// One LED word as the block sends it
typedef struct packed {
    logic [2:0] led_index;
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
    logic       last;
} t_led_word;

// Tracks the LED string: colors, bounce state, prescaler and registers.
// take_word() notes an accepted input word and queues the frame a tick
// produces; check_led_word() compares one output word with the oldest
// queued one.
class led_frame_tracker;
    logic [MODE_W-1:0]   mode;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] prescale;
    logic [COLOR_W-1:0]  colors [NUM_LEDS];
    logic [COLOR_W-1:0]  snapshot [NUM_LEDS];
    int                  scroll_pos;
    logic [1:0]          scroll_dir;
    t_led_word           expected_leds [$];
    int                  errors;

    function new();
        mode       = MODE_HOLD;
        period     = PERIOD_RESET;
        prescale   = '0;
        scroll_pos = 0;
        scroll_dir = DIR_IDLE;
        errors     = 0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            colors[i]   = RAINBOW[i & 7];
            snapshot[i] = '0;
        end
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [PERIOD_W-1:0] data);
        case (idx)
            CFG_ANIM_MODE:   mode = data[MODE_W-1:0];
            CFG_STEP_PERIOD: period = (data > PERIOD_MAX) ? PERIOD_MAX : data;
            default: ;
        endcase
    endfunction

    function void rotate_left();
        logic [COLOR_W-1:0] keep;
        keep = colors[0];
        for (int i = 1; i < NUM_LEDS; i++)
            colors[i-1] = colors[i];
        colors[NUM_LEDS-1] = keep;
    endfunction

    function void rotate_right();
        logic [COLOR_W-1:0] keep;
        keep = colors[NUM_LEDS-1];
        for (int i = NUM_LEDS - 1; i > 0; i--)
            colors[i] = colors[i-1];
        colors[0] = keep;
    endfunction

    // scroll the snapshot out with zero fill, flip direction every N-1 steps
    function void bounce_step();
        int                 src;
        logic [COLOR_W-1:0] c;
        if (scroll_dir == DIR_IDLE) begin
            snapshot   = colors;
            scroll_pos = 0;
            scroll_dir = DIR_FWD;
        end
        scroll_pos++;
        if (scroll_pos >= NUM_LEDS - 1) begin
            scroll_dir = (scroll_dir == DIR_FWD) ? DIR_REV : DIR_FWD;
            scroll_pos = 0;
        end
        for (int i = 0; i < NUM_LEDS; i++) begin
            src = i + scroll_pos;
            c = (src >= NUM_LEDS) ? '0 : snapshot[src];
            if (scroll_dir == DIR_FWD)
                colors[i] = c;
            else
                colors[NUM_LEDS-1-i] = c;
        end
    endfunction

    function void take_word(input logic op, input logic [7:0] idx,
                            input logic [COLOR_W-1:0] color);
        t_led_word w;
        if (op == OP_WRITE) begin
            if (idx < NUM_LEDS)
                colors[idx] = color;
        end else begin
            if (mode != MODE_BOUNCE)
                scroll_dir = DIR_IDLE;
            prescale = prescale + 1'b1;
            if (prescale >= period) begin
                prescale = '0;
                case (mode)
                    MODE_ROT_L:  rotate_left();
                    MODE_ROT_R:  rotate_right();
                    MODE_BOUNCE: bounce_step();
                    default: ;
                endcase
            end
            for (int i = 0; i < NUM_LEDS; i++) begin
                w.led_index = 3'(i);
                w.red       = colors[i][23:20];
                w.green     = colors[i][15:12];
                w.blue      = colors[i][7:4];
                w.last      = (i == NUM_LEDS - 1);
                expected_leds.push_back(w);
            end
        end
    endfunction

    function void check_led_word(input t_led_word got);
        t_led_word want;
        if (expected_leds.size() == 0) begin
            $error("LED word with nothing expected: led_index %0d", got.led_index);
            errors++;
            return;
        end
        want = expected_leds.pop_front();
        if (got.led_index !== want.led_index) begin
            $error("led_index: expected %0d, got %0d", want.led_index, got.led_index);
            errors++;
        end
        if (got.red !== want.red) begin
            $error("dim_red: expected %0h, got %0h", want.red, got.red);
            errors++;
        end
        if (got.green !== want.green) begin
            $error("dim_green: expected %0h, got %0h", want.green, got.green);
            errors++;
        end
        if (got.blue !== want.blue) begin
            $error("dim_blue: expected %0h, got %0h", want.blue, got.blue);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module led_strip_animator_tb;

    // register indexes the block does not decode; writes there must do nothing
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam int RAND_WORDS = 370;
    localparam int SETTLE_CYC = 12;   // covers queue + engine + output register

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        opcode = OP_TICK;
    logic [7:0]  write_index = '0;
    logic [23:0] write_color = '0;
    logic        out_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_led_index;
    logic [3:0]  o_dim_red;
    logic [3:0]  o_dim_green;
    logic [3:0]  o_dim_blue;
    logic        o_frame_last;

    // idling switches, flipped per phase so some stretches run flat out
    bit gap_on = 1'b0;
    bit stall_on = 1'b0;

    led_frame_tracker tracker = new();

    led_strip_animator dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (opcode),
        .i_write_index (write_index),
        .i_write_color (write_color),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_led_index   (o_led_index),
        .o_dim_red     (o_dim_red),
        .o_dim_green   (o_dim_green),
        .o_dim_blue    (o_dim_blue),
        .o_frame_last  (o_frame_last)
    );

    always #6 i_clk = ~i_clk;

    // Present one input word and hold it until taken. The optional gap
    // drops valid first; with no gap valid stays high into the next word.
    task automatic send_word(input logic op, input logic [7:0] idx,
                             input logic [23:0] color);
        int gap;
        gap = gap_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        write_index <= idx;
        write_color <= color;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_word(op, idx, color);
    endtask

    // Stop sending and wait for every queued LED word to come out.
    // Always waits on the clock before it checks, so valid is not driven twice.
    task automatic drain_frames();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_leds.size() != 0);
    endtask

    // Drain, then let trailing writes clear the pipe before touching config
    task automatic quiesce();
        drain_frames();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // New mode and period; upper mode bits get junk, block must mask them
    task automatic set_phase(input logic [MODE_W-1:0] mode, input logic [10:0] period);
        quiesce();
        write_reg(CFG_ANIM_MODE, {9'($urandom), mode});
        write_reg(CFG_STEP_PERIOD, period);
    endtask

    // Output side: random stall before each word, check on handshake
    initial begin
        t_led_word got;
        int        stall;
        do @(posedge i_clk); while (!rst_n);
        forever begin
            stall = stall_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.led_index = o_led_index;
            got.red       = o_dim_red;
            got.green     = o_dim_green;
            got.blue      = o_dim_blue;
            got.last      = o_frame_last;
            tracker.check_led_word(got);
        end
    end

    // Input side: reset, directed words, then random phases
    initial begin
        int                counted;
        int                pick;
        int                n_words;
        logic [MODE_W-1:0] mode;
        logic [10:0]       period;
        logic [7:0]        idx;

        counted = 0;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: hold mode, rainbow colors, period 100
        send_word(OP_TICK, 8'h00, 24'h000000);
        send_word(OP_WRITE, 8'd0, 24'hffffff);
        send_word(OP_WRITE, 8'd7, 24'h000000);
        // past the end of the string: both dropped
        send_word(OP_WRITE, 8'd8, 24'h5a5a5a);
        send_word(OP_WRITE, 8'd255, 24'hffffff);
        send_word(OP_TICK, 8'hff, 24'hffffff);

        // period zero steps on every tick
        set_phase(MODE_ROT_L, 11'd0);
        repeat (2) send_word(OP_TICK, 8'h00, 24'h000000);
        set_phase(MODE_ROT_R, 11'd0);
        repeat (2) send_word(OP_TICK, 8'h00, 24'h000000);

        // unknown registers ignored; oversize period clamps to 2000
        quiesce();
        write_reg(CFG_SPARE_A, 11'h7ff);
        write_reg(CFG_SPARE_B, 11'h555);
        set_phase(MODE_ROT_L, 11'h7ff);
        send_word(OP_TICK, 8'h00, 24'h000000);

        // bounce through a full sweep and the direction flip
        set_phase(MODE_BOUNCE, 11'd1);
        repeat (9) send_word(OP_TICK, 8'h00, 24'h000000);
        // leaving bounce resets it; re-entering takes a fresh snapshot
        set_phase(MODE_HOLD, 11'd1);
        send_word(OP_TICK, 8'h00, 24'h000000);
        set_phase(MODE_BOUNCE, 11'd0);
        send_word(OP_TICK, 8'h00, 24'h000000);

        // random phases, mostly short periods so steps happen often
        while (counted < RAND_WORDS) begin
            mode = MODE_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 19);
            if (pick < 12)
                period = 11'($urandom_range(0, (mode == MODE_BOUNCE) ? 2 : 4));
            else if (pick < 16)
                period = 11'($urandom_range(5, 40));
            else if (pick < 18)
                period = 11'($urandom_range(2000, 2047));
            else
                period = PERIOD_RESET;
            set_phase(mode, period);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 11'($urandom));

            gap_on   = $urandom_range(0, 1);
            stall_on = $urandom_range(0, 1);
            n_words  = $urandom_range(8, 40);
            repeat (n_words) begin
                if ($urandom_range(0, 9) < 3) begin
                    if ($urandom_range(0, 9) == 0)
                        idx = 8'($urandom_range(NUM_LEDS, 255));
                    else
                        idx = 8'($urandom_range(0, NUM_LEDS - 1));
                    send_word(OP_WRITE, idx, 24'($urandom));
                    if (idx < NUM_LEDS)
                        counted++;
                end else begin
                    // payload fields are don't-care on a tick; keep them moving
                    send_word(OP_TICK, 8'($urandom), 24'($urandom));
                    counted++;
                end
                // now and then hold off until the output side catches up
                if ($urandom_range(0, 24) == 0)
                    drain_frames();
            end
        end

        quiesce();
        if (tracker.errors == 0 && tracker.expected_leds.size() == 0)
            $display("led_strip_animator_tb passed");
        else
            $display("led_strip_animator_tb failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10ms;
        $display("led_strip_animator_tb failed");
        $finish;
    end

endmodule
